// ===== hdl/bbs_pkg.sv =====
// Shared constants, codes and inter-module request/response types for the BBS generator.
`default_nettype none
package bbs_pkg;

  localparam int PRIME_BITS_DEF = 32;
  localparam int MAX_RUN_DEF    = 64;
  localparam int WORD_W         = 64;
  localparam int HALF_W         = WORD_W / 2;
  localparam int CFG_IDX_W      = 2;
  localparam int MODE_W         = 2;
  localparam int COUNT_W        = 7;
  localparam int VALUE_W        = 8;
  localparam int STATUS_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BITS    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYTES   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_PRIME = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_SEED  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_START = 2'd3;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] modulus;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } mm_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } gcd_req_t;

  typedef struct packed {
    logic done;
    logic coprime;
  } gcd_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/bbs_stream_if.sv =====
// Valid/ready channel interfaces for request and result transactions.
`default_nettype none
interface bbs_in_if import bbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COUNT_W-1:0] count;
  modport source (output valid, output mode, output count, input ready);
  modport sink   (input valid, input mode, input count, output ready);
endinterface

interface bbs_out_if import bbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source (output valid, output value, output status, output last, input ready);
  modport sink   (input valid, input value, input status, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/bbs_mulmod.sv =====
// Iterative modular squarer: one shared add-mod unit, double then conditional add per bit.
`default_nettype none
module bbs_mulmod import bbs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire mm_req_t req,
  output mm_rsp_t      rsp
);

  localparam int IDX_W = $clog2(WORD_W);

  logic              busy_r, busy_nxt;
  logic              phase_r, phase_nxt;
  logic              done_r, done_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] base_r, base_nxt;
  logic [WORD_W-1:0] mod_r, mod_nxt;
  logic [WORD_W-1:0] opnd;
  logic [WORD_W:0]   sum;
  logic [WORD_W:0]   sum_red;

  // phase 0 doubles the accumulator, phase 1 adds the base
  assign opnd    = phase_r ? base_r : acc_r;
  assign sum     = {1'b0, acc_r} + {1'b0, opnd};
  assign sum_red = (sum >= {1'b0, mod_r}) ? (sum - {1'b0, mod_r}) : sum;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    mod_nxt   = mod_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      idx_nxt   = IDX_W'(WORD_W - 1);
      acc_nxt   = '0;
      base_nxt  = req.base;
      mod_nxt   = req.modulus;
    end else if (busy_r) begin
      acc_nxt = sum_red[WORD_W-1:0];
      if (!phase_r && base_r[idx_r]) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
    end
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    mod_r  <= mod_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule
`default_nettype wire

// ===== hdl/bbs_gcd.sv =====
// Iterative binary GCD, reports whether two nonzero words, at least one of them odd, are coprime.
`default_nettype none
module bbs_gcd import bbs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire gcd_req_t req,
  output gcd_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              coprime_r, coprime_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic              a_gt_b;
  logic [WORD_W-1:0] diff;

  assign a_gt_b = a_r > b_r;
  assign diff   = a_gt_b ? (a_r - b_r) : (b_r - a_r);

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    coprime_nxt = coprime_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      a_nxt    = req.x;
      b_nxt    = req.y;
    end else if (busy_r) begin
      if (a_r == b_r) begin
        busy_nxt    = 1'b0;
        done_nxt    = 1'b1;
        coprime_nxt = (a_r == WORD_W'(1));
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_gt_b) begin
        a_nxt = diff;
      end else begin
        b_nxt = diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      coprime_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
      coprime_r <= coprime_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.coprime = coprime_r;

endmodule
`default_nettype wire

// ===== hdl/bbs_modular_squaring_prng.sv =====
// Blum Blum Shub generator: sequencer, config registers and output register.
// Each squaring mod N runs in the shared add-mod unit: a doubling per bit, plus an add per set bit.
// A bit result costs one squaring; a byte result costs eight squarings.
// Restart: prime and seed checks, a binary GCD, then one squaring.
// One request at a time; in_ready is high only while the sequencer is idle.
// Synchronous active-low reset clears registers, state and started; no clearing pass.
`default_nettype none
module bbs_modular_squaring_prng import bbs_pkg::*; #(
  parameter int PRIME_BITS = PRIME_BITS_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bbs_in_if.sink                    in_ch,
  bbs_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PQ   = 4'd1;
  localparam logic [3:0] ST_SEED = 4'd2;
  localparam logic [3:0] ST_GCD  = 4'd3;
  localparam logic [3:0] ST_SQR  = 4'd4;
  localparam logic [3:0] ST_GEN  = 4'd5;
  localparam logic [3:0] ST_GENW = 4'd6;
  localparam logic [3:0] ST_EMIT = 4'd7;

  logic [PRIME_BITS-1:0] p_r, q_r;
  logic [WORD_W-1:0]     seed_r;

  logic [3:0]          state_r, state_nxt;
  logic                started_r, started_nxt;
  logic [WORD_W-1:0]   residue_r, residue_nxt;
  logic [WORD_W-1:0]   modulus_r, modulus_nxt;
  logic [WORD_W-1:0]   pq_r, pq_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [RUN_W-1:0]    rem_r, rem_nxt;
  logic [2:0]          bit_cnt_r, bit_cnt_nxt;
  logic [VALUE_W-1:0]  byte_r, byte_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_last_r, res_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic [HALF_W-1:0]  p_ext, q_ext;
  logic [WORD_W-1:0]  pq_prod;
  logic [RUN_W-1:0]   run_len;
  logic [VALUE_W-1:0] byte_shift;
  logic               in_fire, out_load;
  mm_req_t            mm_req;
  mm_rsp_t            mm_rsp;
  gcd_req_t           gcd_req;
  gcd_rsp_t           gcd_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r    <= '0;
      q_r    <= '0;
      seed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRIME_P: p_r    <= cfg_wdata[PRIME_BITS-1:0];
        REG_PRIME_Q: q_r    <= cfg_wdata[PRIME_BITS-1:0];
        REG_SEED:    seed_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  assign p_ext   = HALF_W'(p_r);
  assign q_ext   = HALF_W'(q_r);
  assign pq_prod = {{HALF_W{1'b0}}, p_ext} * {{HALF_W{1'b0}}, q_ext};

  // zero counts as one, saturate at the run limit
  always_comb begin
    if (in_ch.count == '0) begin
      run_len = RUN_W'(1);
    end else if (in_ch.count > COUNT_W'(MAX_RUN)) begin
      run_len = RUN_W'(MAX_RUN);
    end else begin
      run_len = RUN_W'(in_ch.count);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign byte_shift  = {byte_r[VALUE_W-2:0], mm_rsp.result[0]};

  assign gcd_req.start = (state_r == ST_SEED) && (seed_r != '0) && (seed_r < pq_r);
  assign gcd_req.x     = seed_r;
  assign gcd_req.y     = pq_r;

  always_comb begin
    mm_req.start   = 1'b0;
    mm_req.base    = residue_r;
    mm_req.modulus = modulus_r;
    if (state_r == ST_GCD) begin
      mm_req.start   = gcd_rsp.done && gcd_rsp.coprime;
      mm_req.base    = seed_r;
      mm_req.modulus = pq_r;
    end else if (state_r == ST_GEN) begin
      mm_req.start = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    started_nxt    = started_r;
    residue_nxt    = residue_r;
    modulus_nxt    = modulus_r;
    pq_nxt         = pq_r;
    mode_nxt       = mode_r;
    rem_nxt        = rem_r;
    bit_cnt_nxt    = bit_cnt_r;
    byte_nxt       = byte_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt      = in_ch.mode;
          rem_nxt       = run_len;
          bit_cnt_nxt   = '0;
          byte_nxt      = '0;
          res_value_nxt = '0;
          res_last_nxt  = 1'b1;
          if (in_ch.mode == MODE_RESTART) begin
            if (p_r[1:0] != 2'b11 || q_r[1:0] != 2'b11) begin
              started_nxt    = 1'b0;
              res_status_nxt = STAT_BAD_PRIME;
              state_nxt      = ST_EMIT;
            end else begin
              state_nxt = ST_PQ;
            end
          end else if (in_ch.mode != MODE_NONE) begin
            if (!started_r) begin
              res_status_nxt = STAT_NOT_START;
              state_nxt      = ST_EMIT;
            end else begin
              res_status_nxt = STAT_OK;
              state_nxt      = ST_GEN;
            end
          end
        end
      end
      ST_PQ: begin
        pq_nxt    = pq_prod;
        state_nxt = ST_SEED;
      end
      ST_SEED: begin
        if (gcd_req.start) begin
          state_nxt = ST_GCD;
        end else begin
          started_nxt    = 1'b0;
          res_status_nxt = STAT_BAD_SEED;
          state_nxt      = ST_EMIT;
        end
      end
      ST_GCD: begin
        if (gcd_rsp.done) begin
          if (gcd_rsp.coprime) begin
            state_nxt = ST_SQR;
          end else begin
            started_nxt    = 1'b0;
            res_status_nxt = STAT_BAD_SEED;
            state_nxt      = ST_EMIT;
          end
        end
      end
      ST_SQR: begin
        if (mm_rsp.done) begin
          residue_nxt    = mm_rsp.result;
          modulus_nxt    = pq_r;
          started_nxt    = 1'b1;
          res_status_nxt = STAT_OK;
          state_nxt      = ST_EMIT;
        end
      end
      ST_GEN: begin
        state_nxt = ST_GENW;
      end
      ST_GENW: begin
        if (mm_rsp.done) begin
          residue_nxt  = mm_rsp.result;
          res_last_nxt = (rem_r == RUN_W'(1));
          if (mode_r == MODE_BITS) begin
            res_value_nxt = VALUE_W'(mm_rsp.result[0]);
            state_nxt     = ST_EMIT;
          end else if (bit_cnt_r == 3'd7) begin
            res_value_nxt = byte_shift;
            bit_cnt_nxt   = '0;
            byte_nxt      = '0;
            state_nxt     = ST_EMIT;
          end else begin
            byte_nxt    = byte_shift;
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            state_nxt   = ST_GEN;
          end
        end
      end
      ST_EMIT: begin
        // hold the result until the output register frees up
        if (out_load) begin
          if (res_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt   = rem_r - RUN_W'(1);
            state_nxt = ST_GEN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      residue_r   <= '0;
      modulus_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      residue_r   <= residue_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pq_r         <= pq_nxt;
    mode_r       <= mode_nxt;
    rem_r        <= rem_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    byte_r       <= byte_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;
  assign out_ch.last   = out_last_r;

  bbs_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  bbs_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gcd_req),
    .rsp   (gcd_rsp)
  );

endmodule
`default_nettype wire

// ===== dv/bbs_prng_checker.sv =====
// Result checker for the BBS generator: tracks config and requests, predicts and compares results.
`timescale 1ns / 100ps
module bbs_prng_checker import bbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  bbs_in_if                    in_mon,
  bbs_out_if                   out_mon,
  output int                   fail_count,
  output int                   pending
);

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } bbs_result_t;

  bbs_result_t       result_q[$];
  bbs_result_t       want;
  logic [HALF_W-1:0] prime_p;
  logic [HALF_W-1:0] prime_q;
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] residue;
  logic [WORD_W-1:0] modulus;
  logic              started;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [WORD_W-1:0] square_mod(input logic [WORD_W-1:0] x,
                                                   input logic [WORD_W-1:0] m);
    logic [2*WORD_W-1:0] wide_x;
    logic [2*WORD_W-1:0] wide_sq;
    wide_x  = {{WORD_W{1'b0}}, x};
    wide_sq = (wide_x * wide_x) % {{WORD_W{1'b0}}, m};
    return wide_sq[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] gcd(input logic [WORD_W-1:0] a,
                                            input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] t;
    while (b != '0) begin
      t = b;
      b = a % b;
      a = t;
    end
    return a;
  endfunction

  function automatic void queue_result(input logic [VALUE_W-1:0] value,
                                       input logic [STATUS_W-1:0] status,
                                       input logic last);
    bbs_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    result_q.insert(result_q.size(), r);
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  task automatic predict_request(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
    logic [WORD_W-1:0]  m;
    logic [VALUE_W-1:0] v;
    int                 n;
    int                 squarings;
    m = {{HALF_W{1'b0}}, prime_p} * {{HALF_W{1'b0}}, prime_q};
    case (mode)
      MODE_RESTART: begin
        // prime check wins over the seed check
        if (prime_p[1:0] != 2'b11 || prime_q[1:0] != 2'b11) begin
          started = 1'b0;
          queue_result('0, STAT_BAD_PRIME, 1'b1);
        end else if (seed == '0 || seed >= m || gcd(seed, m) != 1) begin
          started = 1'b0;
          queue_result('0, STAT_BAD_SEED, 1'b1);
        end else begin
          modulus = m;
          residue = square_mod(seed, m);
          started = 1'b1;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      MODE_NONE: ;
      default: begin
        if (!started || modulus == '0) begin
          queue_result('0, STAT_NOT_START, 1'b1);
        end else begin
          n = (count == 0) ? 1 : (count > MAX_RUN_DEF) ? MAX_RUN_DEF : int'(count);
          squarings = (mode == MODE_BYTES) ? VALUE_W : 1;
          for (int k = 0; k < n; k++) begin
            v = '0;
            // first bit lands in the MSB of a byte
            for (int b = 0; b < squarings; b++) begin
              residue = square_mod(residue, modulus);
              v = {v[VALUE_W-2:0], residue[0]};
            end
            queue_result(v, STAT_OK, k == n - 1);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      prime_p = '0;
      prime_q = '0;
      seed    = '0;
      residue = '0;
      modulus = '0;
      started = 1'b0;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRIME_P: prime_p = cfg_wdata[HALF_W-1:0];
          REG_PRIME_Q: prime_q = cfg_wdata[HALF_W-1:0];
          REG_SEED:    seed    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_request(in_mon.mode, in_mon.count);
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0h status %0d last %0b",
                                    out_mon.value, out_mon.status, out_mon.last));
        end else begin
          want = result_q.pop_front();
          if (out_mon.value !== want.value)
            report_mismatch($sformatf("value %0h, want %0h", out_mon.value, want.value));
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_mon.status, want.status));
          if (out_mon.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_mon.last, want.last));
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the BBS generator: clock, reset, config writes, request stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import bbs_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 10;
  localparam int RANDOM_ITEMS = 195;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 20000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;
  bit                   calm;
  int                   fail_count;
  int                   pending;
  int                   stall_cycles = 0;

  bbs_in_if  in_ch ();
  bbs_out_if out_ch ();

  bbs_modular_squaring_prng dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bbs_prng_checker u_prng_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Abort when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_req(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      in_ch.mode  <= MODE_W'($urandom);
      in_ch.count <= COUNT_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.count <= count;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait out every expected result, then let any ignored request drain
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic load_config(input logic [HALF_W-1:0] p, input logic [HALF_W-1:0] q,
                             input logic [WORD_W-1:0] s);
    settle();
    // upper half of a prime write is junk and must be dropped
    cfg_write(REG_PRIME_P, {$urandom, p});
    cfg_write(REG_PRIME_Q, {$urandom, q});
    cfg_write(REG_SEED, s);
    if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, {$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [HALF_W-1:0]  p;
    logic [HALF_W-1:0]  q;
    logic [WORD_W-1:0]  m;
    logic [WORD_W-1:0]  s;
    logic [MODE_W-1:0]  md;
    logic [COUNT_W-1:0] cnt;
    int                 items_done;
    int                 phase_len;
    int                 r;

    in_ch.valid = 1'b0;
    in_ch.mode  = MODE_NONE;
    in_ch.count = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_PRIME_P;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    calm        = 1'b0;
    items_done  = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Straight out of reset: not started, then a restart with zero primes
    send_req(MODE_BITS, 7'd1);
    send_req(MODE_RESTART, 7'd0);

    load_config(32'd3, 32'd7, 64'd5);
    cfg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_req(MODE_RESTART, 7'd127);
    send_req(MODE_BITS, 7'd0);
    send_req(MODE_BITS, 7'd64);
    send_req(MODE_BYTES, 7'd1);
    send_req(MODE_BITS, 7'd127);
    send_req(MODE_NONE, 7'd5);
    send_req(MODE_BYTES, 7'd3);

    // Bad prime, then generation after a failed restart
    load_config(32'd13, 32'd7, 64'd5);
    send_req(MODE_RESTART, 7'd1);
    send_req(MODE_BYTES, 7'd2);

    // Seed zero, seed equal to N, seed sharing a factor with N
    load_config(32'd11, 32'd19, 64'd0);
    send_req(MODE_RESTART, 7'd0);
    load_config(32'd11, 32'd19, 64'd209);
    send_req(MODE_RESTART, 7'd0);
    load_config(32'd11, 32'd19, 64'd22);
    send_req(MODE_RESTART, 7'd0);
    send_req(MODE_BITS, 7'd4);

    // Both checks fail: the prime status must win
    load_config(32'd13, 32'd9, 64'd0);
    send_req(MODE_RESTART, 7'd0);

    // Widest primes: seed above N, then seed N-1
    load_config(32'hFFFF_FFFB, 32'hFFFF_FFEF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(MODE_RESTART, 7'd0);
    load_config(32'hFFFF_FFFB, 32'hFFFF_FFEF, 64'hFFFF_FFEA_0000_0054);
    send_req(MODE_RESTART, 7'd0);
    send_req(MODE_BYTES, 7'd2);
    send_req(MODE_BITS, 7'd5);
    send_req(MODE_NONE, 7'd127);

    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0000_0001_2345_6789);
    send_req(MODE_RESTART, 7'd0);
    send_req(MODE_BYTES, 7'd1);

    while (items_done < RANDOM_ITEMS) begin
      calm = (items_done >= 90 && items_done < 150);
      r = $urandom_range(9);
      if (r <= 5) begin
        p = ($urandom & ((32'd1 << $urandom_range(4, 16)) - 1)) | 32'd3;
        q = ($urandom & ((32'd1 << $urandom_range(4, 16)) - 1)) | 32'd3;
      end else if (r <= 7) begin
        p = $urandom | 32'd3;
        q = $urandom | 32'd3;
      end else if (r == 8) begin
        p = $urandom;
        q = ($urandom & 32'hFFFF) | 32'd3;
      end else begin
        p = ($urandom & 32'hFFF) | 32'd3;
        q = ($urandom & ~32'd3) | $urandom_range(0, 2);
      end
      m = {32'd0, p} * {32'd0, q};
      case ($urandom_range(9))
        8:       s = {$urandom, $urandom};
        9:       s = {32'd0, p} * $urandom_range(1, 4);
        default: s = (m > 1) ? ({$urandom, $urandom} % (m - 1)) + 1 : {$urandom, $urandom};
      endcase
      load_config(p, q, s);

      // most runs start well formed; a few go straight to generation
      if ($urandom_range(9) != 0) begin
        send_req(MODE_RESTART, COUNT_W'($urandom));
        items_done++;
      end
      phase_len = $urandom_range(8, 25);
      repeat (phase_len) begin
        calm = (items_done >= 90 && items_done < 150);
        r = $urandom_range(99);
        md = (r < 8) ? MODE_RESTART : (r < 52) ? MODE_BITS : (r < 95) ? MODE_BYTES : MODE_NONE;
        r = $urandom_range(99);
        if (md == MODE_BITS)
          cnt = (r < 85) ? COUNT_W'($urandom_range(1, 8)) :
                (r < 92) ? 7'd0 : COUNT_W'($urandom_range(9, 127));
        else if (md == MODE_BYTES)
          cnt = (r < 90) ? COUNT_W'($urandom_range(1, 4)) :
                (r < 95) ? 7'd0 : COUNT_W'($urandom_range(5, 127));
        else
          cnt = COUNT_W'($urandom);
        send_req(md, cnt);
        if (md != MODE_NONE) items_done++;
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
